// ----- design/spg_pkg.sv -----
// Shared types, constants and helpers for the Sobol point generator.
// No dependencies; every other design file imports this package.
`default_nettype none

package spg_pkg;

	localparam int FRACTION_BITS_DEF = 32;
	localparam int MAX_DEGREE_DEF    = 10;
	localparam int WORD_W            = 32;
	localparam int NUM_WORDS         = 32;
	localparam int WADDR_W           = 5;
	localparam int DEG_W             = 4;
	localparam int COEFF_W           = 9;
	localparam int INIT_W            = 55;
	localparam int IDX_W             = 33;
	localparam int CFG_IDX_W         = 2;
	localparam int IN_W              = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_DIM,
		CFG_POLY_DEGREE,
		CFG_POLY_COEFFS,
		CFG_INIT_NUMBERS
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_ZERO,
		OP_STEP,
		OP_HOLD
	} step_op_t;

	typedef struct packed {
		logic               en;
		logic [WADDR_W-1:0] addr;
		logic [WORD_W-1:0]  data;
	} dir_wr_t;

	typedef struct packed {
		step_op_t          op;
		logic [WORD_W-1:0] number;
		logic [WORD_W-1:0] word;
	} step_t;

	// position of the lowest set bit; isolate it, then encode the one-hot word
	function automatic logic [WADDR_W-1:0] trailing_zeros(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0]  low;
		logic [WADDR_W-1:0] r;
		low = x & (~x + WORD_W'(1));
		r   = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (low[i])
				r = r | WADDR_W'(i);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/spg_dirgen.sv -----
// Configuration registers and the direction word sequencer.
// Derives one direction word per cycle after reset and after each write.
// Depends on spg_pkg.
`default_nettype none

module spg_dirgen #(
	parameter int MAX_DEGREE = spg_pkg::MAX_DEGREE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [spg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [spg_pkg::INIT_W-1:0]    cfg_data,
	output logic                              busy,
	output spg_pkg::dir_wr_t                  wr
);
	import spg_pkg::*;

	logic                     first_q;
	logic [DEG_W-1:0]         deg_q;
	logic [COEFF_W-1:0]       coeff_q;
	logic [INIT_W-1:0]        init_q;
	logic                     busy_q;
	logic [WADDR_W-1:0]       cnt_q;
	logic [WORD_W-1:0]        win_q [MAX_DEGREE];

	logic                     cfg_fire;
	logic [DEG_W-1:0]         s_eff;
	logic [DEG_W-1:0]         cidx;
	logic [WORD_W-1:0]        v_first;
	logic [WORD_W-1:0]        v_init;
	logic [WORD_W-1:0]        v_rec;
	logic [WORD_W-1:0]        base;
	logic [WORD_W-1:0]        m_i;
	logic [WORD_W-1:0]        v;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_comb begin
		if (deg_q == '0)
			s_eff = DEG_W'(1);
		else if (deg_q > DEG_W'(MAX_DEGREE))
			s_eff = DEG_W'(MAX_DEGREE);
		else
			s_eff = deg_q;
	end

	always_comb begin
		v_first = {1'b1, {(WORD_W-1){1'b0}}} >> cnt_q;

		m_i = '0;
		for (int k = 1; k <= MAX_DEGREE; k++) begin
			if (cnt_q == WADDR_W'(k - 1))
				m_i = WORD_W'((init_q >> (k * (k - 1) / 2)) & ((INIT_W'(1) << k) - INIT_W'(1)));
		end
		v_init = m_i << (WADDR_W'(WORD_W - 1) - cnt_q);

		base = '0;
		for (int k = 0; k < MAX_DEGREE; k++) begin
			if (s_eff == DEG_W'(k + 1))
				base = win_q[k];
		end
		v_rec = base ^ (base >> s_eff);
		cidx  = '0;
		for (int k = 1; k < MAX_DEGREE; k++) begin
			cidx = s_eff - DEG_W'(1) - DEG_W'(k);
			if ((DEG_W'(k) < s_eff) && coeff_q[cidx])
				v_rec = v_rec ^ win_q[k-1];
		end

		if (first_q)
			v = v_first;
		else if ({1'b0, cnt_q} < {{(WADDR_W+1-DEG_W){1'b0}}, s_eff})
			v = v_init;
		else
			v = v_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			deg_q   <= DEG_W'(1);
			coeff_q <= '0;
			init_q  <= INIT_W'(1);
			busy_q  <= 1'b1;
			cnt_q   <= '0;
		end else if (cfg_fire) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FIRST_DIM:    first_q <= cfg_data[0];
				CFG_POLY_DEGREE:  deg_q   <= cfg_data[DEG_W-1:0];
				CFG_POLY_COEFFS:  coeff_q <= cfg_data[COEFF_W-1:0];
				CFG_INIT_NUMBERS: init_q  <= cfg_data;
				default: ;
			endcase
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + WADDR_W'(1);
			if (cnt_q == WADDR_W'(NUM_WORDS - 1))
				busy_q <= 1'b0;
		end
	end

	// shift the window of recent words
	always_ff @(posedge clk) begin
		if (busy_q) begin
			win_q[0] <= v;
			for (int k = 1; k < MAX_DEGREE; k++)
				win_q[k] <= win_q[k-1];
		end
	end

	assign busy    = busy_q;
	assign wr.en   = busy_q;
	assign wr.addr = cnt_q;
	assign wr.data = v;

endmodule

`default_nettype wire

// ----- design/spg_index.sv -----
// Input stage: index counter, Gray-code column select and the direction word memory.
// Depends on spg_pkg; written by spg_dirgen, feeds spg_accum.
`default_nettype none

module spg_index (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              restart,
	input  wire logic              busy,
	input  wire spg_pkg::dir_wr_t  wr,
	input  wire logic              s2_ready,
	output logic                   valid_s1,
	output spg_pkg::step_t         step_s1
);
	import spg_pkg::*;

	logic [WORD_W-1:0]  mem [NUM_WORDS];
	logic [IDX_W-1:0]   idx_q;
	logic               v_s1;
	step_op_t           op_s1;
	logic [WORD_W-1:0]  num_s1;
	logic [WORD_W-1:0]  word_s1;

	logic               en1;
	logic               accept;
	step_op_t           op_c;
	logic [WORD_W-1:0]  num_c;
	logic [IDX_W-1:0]   idx_c;
	logic [WADDR_W-1:0] col;

	assign en1      = !v_s1 || s2_ready;
	assign in_ready = en1 && !busy;
	assign accept   = in_valid && in_ready;
	assign col      = trailing_zeros(idx_q[WORD_W-1:0]);

	always_comb begin
		if (restart || idx_q == '0) begin
			op_c  = OP_ZERO;
			num_c = '0;
			idx_c = IDX_W'(1);
		end else if (idx_q[IDX_W-1]) begin
			op_c  = OP_HOLD;
			num_c = '1;
			idx_c = idx_q;
		end else begin
			op_c  = OP_STEP;
			num_c = idx_q[WORD_W-1:0];
			idx_c = idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (accept)
				idx_q <= idx_c;
			if (en1)
				v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		if (accept) begin
			word_s1 <= mem[col];
			op_s1   <= op_c;
			num_s1  <= num_c;
		end
	end

	assign valid_s1       = v_s1;
	assign step_s1.op     = op_s1;
	assign step_s1.number = num_s1;
	assign step_s1.word   = word_s1;

endmodule

`default_nettype wire

// ----- design/spg_accum.sv -----
// Point accumulator and result register.
// Depends on spg_pkg; fed by spg_index.
`default_nettype none

module spg_accum #(
	parameter int FRACTION_BITS = spg_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        valid_s1,
	input  wire spg_pkg::step_t              step_s1,
	output logic                             s2_ready,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [FRACTION_BITS-1:0]         point_fraction,
	output logic [spg_pkg::WORD_W-1:0]       point_number,
	output logic                             exhausted
);
	import spg_pkg::*;

	logic [WORD_W-1:0] point_q;
	logic              valid_s2;
	logic [WORD_W-1:0] num_s2;
	logic              exh_s2;

	assign s2_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				case (step_s1.op)
					OP_ZERO: point_q <= '0;
					OP_STEP: point_q <= point_q ^ step_s1.word;
					OP_HOLD: point_q <= point_q;
					default: point_q <= point_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			num_s2 <= step_s1.number;
			exh_s2 <= (step_s1.op == OP_HOLD);
		end
	end

	assign out_valid      = valid_s2;
	assign point_fraction = point_q[WORD_W-1 -: FRACTION_BITS];
	assign point_number   = num_s2;
	assign exhausted      = exh_s2;

endmodule

`default_nettype wire

// ----- design/sobol_point_generator_top.sv -----
// Top level of the Sobol point generator, one dimension in Gray-code order.
// Depends on spg_pkg, spg_dirgen, spg_index and spg_accum.
//
// channel  direction  handshake                tdata / payload
// -------  ---------  -----------------------  ---------------------------------------
// s_       in         s_tvalid / s_tready      [0] restart
// m_       out        m_tvalid / m_tready      fraction, number[32], exhausted[1]
// cfg_     in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One transaction per cycle unless busy or stalled; input is registered in s1, then s2.
// After reset and after every configuration write the sequencer derives the 32
// direction words, one per cycle; s_tready stays low meanwhile.
// A stalled m_ side holds the result register; one more item may enter and wait
// in the input stage before s_tready drops.
`default_nettype none

module sobol_point_generator_top #(
	parameter int FRACTION_BITS = spg_pkg::FRACTION_BITS_DEF,
	parameter int MAX_DEGREE    = spg_pkg::MAX_DEGREE_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      s_tvalid,
	output logic                                           s_tready,
	input  wire logic [spg_pkg::IN_W-1:0]                  s_tdata,  // [0] restart
	output logic                                           m_tvalid,
	input  wire logic                                      m_tready,
	// point_fraction, point_number, exhausted, then zero fill
	output logic [((FRACTION_BITS+spg_pkg::WORD_W+1+7)/8)*8-1:0] m_tdata,
	input  wire logic                                      cfg_valid,
	output logic                                           cfg_ready,
	input  wire logic [spg_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  wire logic [spg_pkg::INIT_W-1:0]                cfg_data
);
	import spg_pkg::*;

	localparam int OUT_W = ((FRACTION_BITS + WORD_W + 1 + 7) / 8) * 8;

	logic                     busy;
	dir_wr_t                  wr;
	logic                     s2_ready;
	logic                     valid_s1;
	step_t                    step_s1;
	logic [FRACTION_BITS-1:0] point_fraction;
	logic [WORD_W-1:0]        point_number;
	logic                     exhausted;

	spg_dirgen #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_dirgen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.wr        (wr)
	);

	spg_index u_index (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.restart  (s_tdata[0]),
		.busy     (busy),
		.wr       (wr),
		.s2_ready (s2_ready),
		.valid_s1 (valid_s1),
		.step_s1  (step_s1)
	);

	spg_accum #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.step_s1        (step_s1),
		.s2_ready       (s2_ready),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.point_fraction (point_fraction),
		.point_number   (point_number),
		.exhausted      (exhausted)
	);

	assign m_tdata = OUT_W'({exhausted, point_number, point_fraction});

endmodule

`default_nettype wire

// ----- design/spg_checker.sv -----
// Port-level checks for the Sobol point generator, bound to the top level.
// Depends on spg_pkg and sobol_point_generator_top.
`default_nettype none

module spg_checker #(
	parameter int FRACTION_BITS = spg_pkg::FRACTION_BITS_DEF
) (
	input wire logic                                      clk,
	input wire logic                                      arst_n,
	input wire logic                                      s_tready,
	input wire logic                                      m_tvalid,
	input wire logic                                      m_tready,
	input wire logic [((FRACTION_BITS+spg_pkg::WORD_W+1+7)/8)*8-1:0] m_tdata,
	input wire logic                                      cfg_valid,
	input wire logic                                      cfg_ready
);
	import spg_pkg::*;

	localparam int NUM_LO = FRACTION_BITS;
	localparam int EXH    = FRACTION_BITS + WORD_W;

	logic [WORD_W-1:0] number;

	assign number = m_tdata[EXH-1:NUM_LO];

	a_cfg_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !s_tready)
		else $error("input taken right after a configuration transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_exhausted_number: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[EXH] |-> number == '1)
		else $error("exhausted result without the last index");

	a_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[EXH] && number == '0 |-> m_tdata[FRACTION_BITS-1:0] == '0)
		else $error("point zero is not zero");

endmodule

bind sobol_point_generator_top spg_checker #(
	.FRACTION_BITS(FRACTION_BITS)
) u_spg_checker (.*);

`default_nettype wire
